@@ rtl/core/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, constants and helper functions of the priority voice
// allocator: request and result structs, operation codes, control bundles.
// ----------------------------------------------------------------------------
package pva_pkg;

    // Build size and field widths
    localparam int NUM_VOICES = 8;
    localparam int VOICE_ID_W = 5;
    localparam int MASK_W     = 32;
    localparam int SRC_W      = 16;
    localparam int SND_W      = 8;
    localparam int PRI_W      = 8;
    localparam int CNT_W      = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CNT_W-1:0] ACTIVE_RESET = 6'd8;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_STOP_SRC = 2'd1,
        OP_FINISHED = 2'd2,
        OP_STOP_ALL = 2'd3
    } t_pva_op;

    typedef struct packed {
        t_pva_op              operation;
        logic                 source_present;
        logic [SRC_W-1:0]     source_id;
        logic [SND_W-1:0]     sound_id;
        logic [PRI_W-1:0]     request_priority;
        logic [VOICE_ID_W-1:0] voice_index;
    } t_pva_in;

    typedef struct packed {
        logic                  status;
        logic [VOICE_ID_W-1:0] granted_voice;
        logic [MASK_W-1:0]     stopped_mask;
    } t_pva_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic stop;
        logic commit;
    } t_pva_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;
    } t_pva_stat;

    // Keep only the lowest set bit
    function automatic logic [NUM_VOICES-1:0] lowest_onehot(
        input logic [NUM_VOICES-1:0] vec
    );
        return vec & (~vec + {{(NUM_VOICES-1){1'b0}}, 1'b1});
    endfunction

    // One-hot to voice number
    function automatic logic [VOICE_ID_W-1:0] onehot_to_index(
        input logic [NUM_VOICES-1:0] oh
    );
        logic [VOICE_ID_W-1:0] idx;
        idx = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (oh[v]) begin
                idx = idx | VOICE_ID_W'(v);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/pva_ctrl.sv @@
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer of the allocator: takes one request, runs the source stop pass,
// then the commit pass once the result register can take a new transfer.
// ----------------------------------------------------------------------------
module pva_ctrl
    import pva_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_pva_stat i_stat,
    output logic      o_in_stall,
    output t_pva_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STOP,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    // Commands decoded from state
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
        o_cmd.stop   = (r_state == S_STOP);
        o_cmd.commit = (r_state == S_COMMIT) && i_stat.slot_free;
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_STOP;
                        r_in_stall <= 1'b1;
                    end
                end
                S_STOP: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_stat.slot_free) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

@@ rtl/core/pva_dpath.sv @@
// ----------------------------------------------------------------------------
// pva_dpath
// Voice table and search logic: per-voice source and priority compares,
// lowest-index selection, table update and the result register.
// ----------------------------------------------------------------------------
module pva_dpath
    import pva_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pva_cmd         i_cmd,
    input  t_pva_in          i_in_item,
    input  logic [CNT_W-1:0] i_active,
    input  logic             i_out_stall,
    output t_pva_stat        o_stat,
    output logic             o_out_valid,
    output t_pva_out         o_out_item
);

    // Latched request and partial stop mask
    t_pva_in               r_req;
    logic [NUM_VOICES-1:0] r_mask;

    // Voice table
    logic [NUM_VOICES-1:0] r_busy;
    logic [NUM_VOICES-1:0] r_has;
    logic [SRC_W-1:0]      r_src [NUM_VOICES];
    logic [PRI_W-1:0]      r_pri [NUM_VOICES];

    // Result register
    logic     r_out_valid;
    t_pva_out r_out;

    logic [NUM_VOICES-1:0] in_use;
    logic [NUM_VOICES-1:0] same;
    logic [NUM_VOICES-1:0] evict_cand;
    logic [NUM_VOICES-1:0] fin_hit;
    logic [NUM_VOICES-1:0] stop_hit;
    logic [NUM_VOICES-1:0] reuse;
    logic [NUM_VOICES-1:0] pick;
    logic [NUM_VOICES-1:0] n_busy;
    logic [NUM_VOICES-1:0] n_mask;
    logic [NUM_VOICES-1:0] wr_en;
    logic [SRC_W-1:0]      req_src;
    t_pva_out              n_out;

    // Per-voice compares
    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            in_use[v]     = CNT_W'(v) < i_active;
            same[v]       = (r_has[v] == r_req.source_present) &&
                            (!r_req.source_present || (r_src[v] == r_req.source_id));
            evict_cand[v] = in_use[v] && r_busy[v] &&
                            (r_pri[v] >= r_req.request_priority);
            fin_hit[v]    = r_busy[v] && (VOICE_ID_W'(v) == r_req.voice_index);
        end
    end

    // Lowest-index selections
    assign stop_hit = lowest_onehot(in_use & r_busy & same);
    assign reuse    = lowest_onehot(in_use &
                                    (~r_busy | (same & {NUM_VOICES{r_req.source_present}})));
    assign pick     = (|reuse) ? reuse : lowest_onehot(evict_cand);
    assign req_src  = r_req.source_present ? r_req.source_id : '0;

    // Table update and result per operation
    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        wr_en  = '0;
        n_out  = '0;
        if (i_cmd.stop) begin
            if (r_req.operation == OP_START || r_req.operation == OP_STOP_SRC) begin
                n_busy = r_busy & ~stop_hit;
                n_mask = stop_hit;
            end else begin
                n_mask = '0;
            end
        end else if (i_cmd.commit) begin
            unique case (r_req.operation)
                OP_START: begin
                    if (|pick) begin
                        n_busy              = r_busy | pick;
                        wr_en               = pick;
                        n_out.status        = STATUS_OK;
                        n_out.granted_voice = onehot_to_index(pick);
                        n_out.stopped_mask  = MASK_W'(r_mask | (r_busy & pick));
                    end else begin
                        n_out.status        = STATUS_REJECT;
                        n_out.stopped_mask  = MASK_W'(r_mask);
                    end
                end
                OP_STOP_SRC: begin
                    n_out.stopped_mask = MASK_W'(r_mask);
                end
                OP_FINISHED: begin
                    n_busy             = r_busy & ~fin_hit;
                    n_out.stopped_mask = MASK_W'(fin_hit);
                end
                OP_STOP_ALL: begin
                    n_busy             = '0;
                    n_out.stopped_mask = MASK_W'(r_busy);
                end
                default: begin
                    n_out = '0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
        r_mask <= n_mask;
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (wr_en[v]) begin
                r_has[v] <= r_req.source_present;
                r_src[v] <= req_src;
                r_pri[v] <= r_req.request_priority;
            end
        end
    end

    assign o_stat.slot_free = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

endmodule

@@ rtl/core/priority_voice_allocator.sv @@
// A request is loaded on its transfer; the stop pass follows, then the commit pass
// loads the result register. One request at a time: the next is taken only after both passes.
// A stalled result holds the commit pass until the output transfer is free.
// Reset (synchronous, active low): all voices free, active_voices = 8.
// ----------------------------------------------------------------------------
// priority_voice_allocator
// Voice table with priority allocation, APB register for the active count.
// ----------------------------------------------------------------------------
module priority_voice_allocator
    import pva_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_pva_in               i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_pva_out              o_out_item,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] active_eff;
    t_pva_cmd         cmd;
    t_pva_stat        stat;

    // Register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_active <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : APB_DATA_W'(r_active);

    // Clamp to the built voice count
    assign active_eff = (r_active < CNT_W'(NUM_VOICES)) ? r_active : CNT_W'(NUM_VOICES);

    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pva_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_active    (active_eff),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/core/pva_checker.sv @@
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker
    import pva_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input t_pva_in               i_in_item,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input t_pva_out              o_out_item,
    input logic                  i_out_stall,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A rejected start grants no voice
    a_reject_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STATUS_REJECT) |->
            (o_out_item.granted_voice == '0))
        else $error("rejected start reports a voice");

    // One request in flight at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // Nothing left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_voice_allocator. A clocked driver feeds
// requests from a queue of pending items, and a monitor predicts every
// accepted request against its own copy of the voice table. Each result is
// then checked field by field. The active voice count is set over the APB
// port between phases, and both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import pva_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_PCT     = 23;
    localparam int NUM_PHASES   = 8;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_VOICES = '0;

    // Active count and request count of each random phase
    localparam logic [CNT_W-1:0] PHASE_ACTIVE [NUM_PHASES] =
        '{6'd8, 6'd1, 6'd32, 6'd4, 6'd0, 6'd7, 6'd2, 6'd8};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{250, 150, 200, 200, 50, 200, 150, 250};
    localparam logic [SRC_W-1:0] SRC_POOL [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                                  16'h1234, 16'h00AA, 16'h5555, 16'hAAAA};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_pva_in               i_in_item   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_pva_out              o_out_item;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    priority_voice_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow voice table and active count
    logic [CNT_W-1:0] act_count = ACTIVE_RESET;
    logic             v_busy   [NUM_VOICES];
    logic             v_hassrc [NUM_VOICES];
    logic [SRC_W-1:0] v_src    [NUM_VOICES];
    logic [SND_W-1:0] v_snd    [NUM_VOICES];
    logic [PRI_W-1:0] v_pri    [NUM_VOICES];

    t_pva_in  pending_reqs [$];
    t_pva_out expected_results [$];
    t_pva_out got;
    t_pva_out want;

    logic        in_taken  = 1'b0;
    logic        calm      = 1'b0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          err_count = 0;
    int unsigned cycles    = 0;
    int unsigned n_reqs    = 0;
    int unsigned n_rejects = 0;
    int unsigned n_stops   = 0;

    initial begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            v_busy[v] = 1'b0;
        end
    end

    function automatic logic src_match(input int v, input logic has,
                                       input logic [SRC_W-1:0] src);
        if (v_hassrc[v] != has) return 1'b0;
        return !has || (v_src[v] == src);
    endfunction

    function automatic logic [MASK_W-1:0] release_voice(input int v);
        if (v < NUM_VOICES && v_busy[v]) begin
            v_busy[v] = 1'b0;
            return MASK_W'(1) << v;
        end
        return '0;
    endfunction

    function automatic logic [MASK_W-1:0] stop_source(input int n, input logic has,
                                                      input logic [SRC_W-1:0] src);
        for (int v = 0; v < n; v++) begin
            if (v_busy[v] && src_match(v, has, src)) return release_voice(v);
        end
        return '0;
    endfunction

    // Apply one request to the shadow table and return its result
    function automatic t_pva_out alloc_predict(input t_pva_in req);
        t_pva_out         res;
        int               n;
        int               hit;
        logic             has;
        logic [SRC_W-1:0] src;
        res = '0;
        hit = -1;
        has = req.source_present;
        src = has ? req.source_id : '0;
        n   = (int'(act_count) < NUM_VOICES) ? int'(act_count) : NUM_VOICES;
        case (req.operation)
            OP_START: begin
                res.stopped_mask = stop_source(n, has, src);
                for (int v = 0; v < n && hit < 0; v++) begin
                    if (!v_busy[v]) begin
                        hit = v;
                    end else if (has && src_match(v, has, src)) begin
                        res.stopped_mask |= release_voice(v);
                        hit = v;
                    end
                end
                // No free voice: evict the first of no higher precedence
                for (int v = 0; v < n && hit < 0; v++) begin
                    if (v_busy[v] && v_pri[v] >= req.request_priority) begin
                        res.stopped_mask |= release_voice(v);
                        hit = v;
                    end
                end
                if (hit >= 0) begin
                    v_busy[hit]   = 1'b1;
                    v_hassrc[hit] = has;
                    v_src[hit]    = src;
                    v_snd[hit]    = req.sound_id;
                    v_pri[hit]    = req.request_priority;
                    res.granted_voice = VOICE_ID_W'(hit);
                end else begin
                    res.status = STATUS_REJECT;
                end
            end
            OP_STOP_SRC: res.stopped_mask = stop_source(n, has, src);
            OP_FINISHED: res.stopped_mask = release_voice(int'(req.voice_index));
            default: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    res.stopped_mask |= release_voice(v);
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_pva_in mk_req(input t_pva_op op, input logic has,
                                       input logic [SRC_W-1:0] src,
                                       input logic [SND_W-1:0] snd,
                                       input logic [PRI_W-1:0] pri,
                                       input logic [VOICE_ID_W-1:0] idx);
        t_pva_in r;
        r.operation        = op;
        r.source_present   = has;
        r.source_id        = src;
        r.sound_id         = snd;
        r.request_priority = pri;
        r.voice_index      = idx;
        return r;
    endfunction

    // Random request: small source pool so sources collide, biased priorities
    function automatic t_pva_in rand_request();
        t_pva_in r;
        int      pick;
        r.sound_id         = SND_W'($urandom);
        r.request_priority = $urandom_range(1) ? PRI_W'($urandom)
                                               : PRI_W'($urandom_range(3) * 85);
        r.source_present   = ($urandom_range(99) < 75);
        pick               = $urandom_range(9);
        r.source_id        = (pick < 8) ? SRC_POOL[pick] : SRC_W'($urandom);
        r.voice_index      = ($urandom_range(3) == 0) ? VOICE_ID_W'($urandom)
                                                      : VOICE_ID_W'($urandom_range(NUM_VOICES + 1));
        pick = $urandom_range(99);
        if (pick < 62)      r.operation = OP_START;
        else if (pick < 80) r.operation = OP_STOP_SRC;
        else if (pick < 97) r.operation = OP_FINISHED;
        else                r.operation = OP_STOP_ALL;
        return r;
    endfunction

    // Request driver: a presented item holds until its transfer
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_item  <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, plus the long hold-off
    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < IDLE_PCT);
    end

    // Long hold-off counter
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check result transfers, then predict request transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_item;
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        err_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.granted_voice !== want.granted_voice) begin
                        err_count++;
                        $display("%0t: granted_voice expected %0d actual %0d",
                                 $time, want.granted_voice, got.granted_voice);
                    end
                    if (got.stopped_mask !== want.stopped_mask) begin
                        err_count++;
                        $display("%0t: stopped_mask expected %h actual %h",
                                 $time, want.stopped_mask, got.stopped_mask);
                    end
                    if (want.status == STATUS_REJECT) n_rejects++;
                    if (want.stopped_mask != '0) n_stops++;
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(alloc_predict(i_in_item));
                n_reqs++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Wait until every request is through and the block has settled
    task automatic drain_wait();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the active count, then read it back
    task automatic set_active(input logic [CNT_W-1:0] count);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_VOICES;
        pwdata  <= APB_DATA_W'(count);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        act_count = count;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(count)) begin
            err_count++;
            $display("%0t: active_voices readback expected %h actual %h",
                     $time, APB_DATA_W'(count), prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill the table, reuse, evict, reject, stops, finished cases
        pending_reqs.push_back(mk_req(OP_STOP_ALL, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'hFFFF, 8'd255, 8'd255, 5'd31));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h0000, 8'd0, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b0, 16'hFFFF, 8'd17, 8'd128, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h0001, 8'd18, 8'd200, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h8000, 8'd19, 8'd10, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h1234, 8'd20, 8'd255, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'hAAAA, 8'd21, 8'd100, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h5555, 8'd22, 8'd255, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h00AA, 8'd23, 8'd255, 5'd0));
        // Table full: same source, null source, eviction, rejection
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h0001, 8'd24, 8'd60, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b0, 16'h1234, 8'd25, 8'd90, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h4321, 8'd26, 8'd255, 5'd0));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h4322, 8'd27, 8'd255, 5'd0));
        pending_reqs.push_back(mk_req(OP_STOP_SRC, 1'b1, 16'hFFFF, 8'd0, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_STOP_SRC, 1'b1, 16'h7777, 8'd0, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_STOP_SRC, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_FINISHED, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd1));
        pending_reqs.push_back(mk_req(OP_FINISHED, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd1));
        pending_reqs.push_back(mk_req(OP_FINISHED, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd31));
        pending_reqs.push_back(mk_req(OP_FINISHED, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd8));
        drain_wait();

        // Active count below the busy voices: finished and stop-all beyond it
        set_active(6'd2);
        pending_reqs.push_back(mk_req(OP_FINISHED, 1'b0, 16'h0000, 8'd0, 8'd0, 5'd6));
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h0BAD, 8'd30, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_STOP_ALL, 1'b1, 16'hFFFF, 8'd255, 8'd255, 5'd31));
        drain_wait();

        // No active voices
        set_active(6'd0);
        pending_reqs.push_back(mk_req(OP_START, 1'b1, 16'h0001, 8'd40, 8'd0, 5'd0));
        pending_reqs.push_back(mk_req(OP_STOP_SRC, 1'b1, 16'h0001, 8'd0, 8'd0, 5'd0));

        // Random phases over several active counts
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_wait();
            set_active(PHASE_ACTIVE[p]);
            calm = (p == 3);
            for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
                pending_reqs.push_back(rand_request());
            end
            if (p == 0) hold_req = 1'b1;
        end
        drain_wait();

        $display("Checked %0d requests over %0d active-count settings and the APB readback.",
                 n_reqs, NUM_PHASES + 2);
        $display("%0d starts were rejected and %0d results stopped at least one voice.",
                 n_rejects, n_stops);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
